// ===== sv/kpdc_pkg.sv =====
// ----------------------------------------------------------------------------
// kpdc_pkg
// Shared types and constants of the key press duration classifier.
// ----------------------------------------------------------------------------
package kpdc_pkg;

  localparam int unsigned KeyCountDefault = 5;
  localparam int unsigned LevelBits       = 5;
  localparam int unsigned KeyW            = 3;
  localparam int unsigned CountW          = 8;
  localparam int unsigned CfgIdxW         = 1;

  localparam logic [CountW-1:0] LongHoldReset     = CountW'(32 * 3);
  localparam logic [CountW-1:0] VeryLongHoldReset = CountW'(32 * 6);

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_DELAY = 2'd1,
    MODE_HOLD  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    EV_SHORT     = 2'd0,
    EV_LONG      = 2'd1,
    EV_VERY_LONG = 2'd2
  } event_e;

  typedef enum logic {
    FUNC_EDGE = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LONG_HOLD      = 1'b0,
    CFG_VERY_LONG_HOLD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic             valid;
    event_e           kind;
    logic [KeyW-1:0]  key;
  } result_t;

endpackage

// ===== sv/kpdc_core.sv =====
// ----------------------------------------------------------------------------
// kpdc_core
// Mode, latched key and hold counter; decides the event for each item.
// ----------------------------------------------------------------------------
module kpdc_core import kpdc_pkg::*; #(
  parameter int unsigned KEY_COUNT = KeyCountDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 func_i,
  input  logic [KeyW-1:0]      edge_key_i,
  input  logic [LevelBits-1:0] key_levels_i,
  input  logic [CountW-1:0]    long_hold_i,
  input  logic [CountW-1:0]    very_long_hold_i,
  output result_t              result_o
);

  mode_e             mode_q, mode_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] count_inc;
  logic              pressed;

  assign count_inc = count_q + CountW'(1);

  always_comb begin
    pressed = 1'b0;
    if (key_q < KeyW'(LevelBits)) begin
      pressed = !key_levels_i[key_q];
    end
  end

  always_comb begin
    mode_d   = mode_q;
    key_d    = key_q;
    count_d  = count_q;
    result_o = '{valid: 1'b0, kind: EV_SHORT, key: key_q};
    if (func_i == FUNC_EDGE) begin
      // latch a new press only when idle and the key exists
      if (mode_q != MODE_DELAY && mode_q != MODE_HOLD &&
          32'(edge_key_i) < KEY_COUNT) begin
        mode_d = MODE_DELAY;
        key_d  = edge_key_i;
      end
    end else begin
      unique case (mode_q)
        MODE_DELAY: begin
          count_d = CountW'(1);
          mode_d  = MODE_HOLD;
        end
        MODE_HOLD: begin
          if (pressed) begin
            count_d = count_inc;
            if (count_inc == very_long_hold_i) begin
              mode_d          = MODE_IDLE;
              result_o.valid  = 1'b1;
              result_o.kind   = EV_VERY_LONG;
            end else if (count_inc == long_hold_i) begin
              result_o.valid  = 1'b1;
              result_o.kind   = EV_LONG;
            end
          end else begin
            mode_d = MODE_IDLE;
            if (count_q < long_hold_i) begin
              result_o.valid = 1'b1;
              result_o.kind  = EV_SHORT;
            end
          end
        end
        default: begin
          // idle: drop the tick
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      key_q   <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      key_q   <= key_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== sv/key_press_duration_classifier.sv =====
// ----------------------------------------------------------------------------
// key_press_duration_classifier
// Classifies presses on active-low keys as short, long or very long holds.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i/in_ready_o) carries either a key falling
//   edge (func_i = 0, edge_key_i) or a timer tick (func_i = 1) together with
//   the current key levels. Each transfer yields zero or one event on the
//   output channel (out_valid_o/out_ready_i): event_kind_o, event_key_o.
//   The configuration channel (cfg_valid_i/cfg_ready_o) writes the long and
//   very long thresholds; it is always ready and must be written only while
//   idle, which the block does not enforce. An event appears in the cycle
//   after the transfer that causes it. Throughput: one item per cycle. The
//   single output register sets this: a new item is taken whenever that
//   register is empty or being drained. If the receiver stalls with an event
//   pending, in_ready_o drops until the event is taken; items that produce no
//   event wait as well. Reset puts the block in idle with count and latched
//   key at zero and loads the thresholds with 96 and 192 ticks.
// ----------------------------------------------------------------------------
module key_press_duration_classifier import kpdc_pkg::*; #(
  parameter int unsigned KEY_COUNT = KeyCountDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [KeyW-1:0]      edge_key_i,
  input  logic [LevelBits-1:0] key_levels_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           event_kind_o,
  output logic [KeyW-1:0]      event_key_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CountW-1:0]    cfg_data_i
);

  logic [CountW-1:0] long_hold_q;
  logic [CountW-1:0] very_long_hold_q;
  logic              in_accept;
  result_t           result;
  logic              out_valid_q, out_valid_d;
  event_e            kind_q;
  logic [KeyW-1:0]   key_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_hold_q      <= LongHoldReset;
      very_long_hold_q <= VeryLongHoldReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LONG_HOLD:      long_hold_q      <= cfg_data_i;
        CFG_VERY_LONG_HOLD: very_long_hold_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  kpdc_core #(
    .KEY_COUNT(KEY_COUNT)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_accept),
    .func_i          (func_i),
    .edge_key_i      (edge_key_i),
    .key_levels_i    (key_levels_i),
    .long_hold_i     (long_hold_q),
    .very_long_hold_i(very_long_hold_q),
    .result_o        (result)
  );

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (in_accept) begin
      out_valid_d = result.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // load payload only with a fresh event
  always_ff @(posedge clk_i) begin
    if (in_accept && result.valid) begin
      kind_q <= result.kind;
      key_q  <= result.key;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = kind_q;
  assign event_key_o  = key_q;

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_kind_o != 2'd3))
    else $error("event kind out of range");

  a_key_exists: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(event_key_o) < KEY_COUNT))
    else $error("event for a key that does not exist");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while an event is stalled");

  a_event_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !in_accept) |=> !out_valid_o)
    else $error("event without a transfer");

endmodule
